// ===== src/rcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants for the RTCP compound packet splitter.
// ----------------------------------------------------------------------------
package rcs_pkg;

  localparam int unsigned HdrBytes   = 4;
  localparam int unsigned PadBit     = 5;
  localparam int unsigned MaxResults = 4;
  localparam int unsigned ResDepth   = 8;
  localparam int unsigned SizeMinW   = 19;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_TYPE_MIN   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TYPE_MAX   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WHOLE_MODE = 2'd2;

  localparam logic [7:0] TypeMinReset = 8'd200;
  localparam logic [7:0] TypeMaxReset = 8'd204;

  typedef struct packed {
    logic [7:0]  in_byte;
    logic        datagram_first;
    logic        datagram_last;
    logic [11:0] datagram_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_start;
    logic       packet_end;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] type_min;
    logic [7:0] type_max;
    logic       whole_datagram_mode;
  } cfg_t;

  typedef struct packed {
    logic [2:0] count;
  } push_t;

endpackage

// ===== src/rcs_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_core
// Per-byte datagram tracking, header hold and check; emits up to four
// results for each accepted byte.
// ----------------------------------------------------------------------------
module rcs_core #(
  parameter int unsigned MAX_DATAGRAM = 2048
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  rcs_pkg::cfg_t                             cfg_i,
  input  logic                                      in_fire_i,
  input  rcs_pkg::in_item_t                         in_data_i,
  output rcs_pkg::push_t                            push_o,
  output rcs_pkg::out_item_t [rcs_pkg::MaxResults-1:0] res_o
);
  import rcs_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_DATAGRAM + 1);
  localparam int unsigned LW  = (CW > 12) ? CW : 12;
  localparam int unsigned SZW = (CW + 2 > SizeMinW) ? CW + 2 : SizeMinW;

  logic [7:0]    hold_q [3];
  logic [7:0]    hold_d [3];
  logic [1:0]    hcnt_q, hcnt_d;
  logic [CW-1:0] dg_left_q, dg_left_d;
  logic [CW-1:0] pkt_left_q, pkt_left_d;
  logic          first_q, first_d;
  logic          disc_q, disc_d;

  logic [CW-1:0]  dg_cur;
  logic [15:0]    len_word;
  logic [SZW-1:0] pkt_size;
  logic [SZW-1:0] avail;
  logic           hdr_ok;

  assign len_word = {hold_q[2], in_data_i.in_byte};
  assign pkt_size = (SZW'(len_word) + SZW'(1)) << 2;

  always_comb begin
    hold_d     = hold_q;
    hcnt_d     = hcnt_q;
    dg_left_d  = dg_left_q;
    pkt_left_d = pkt_left_q;
    first_d    = first_q;
    disc_d     = disc_q;
    dg_cur     = '0;
    avail      = '0;
    hdr_ok     = 1'b0;
    push_o     = '0;
    res_o      = '0;

    if (in_data_i.datagram_first) begin
      if (LW'(in_data_i.datagram_length) > LW'(MAX_DATAGRAM)) begin
        dg_left_d = CW'(MAX_DATAGRAM);
      end else begin
        dg_left_d = CW'(in_data_i.datagram_length);
      end
      pkt_left_d = '0;
      hcnt_d     = '0;
      first_d    = 1'b1;
      disc_d     = 1'b0;
    end

    if (!disc_d && dg_left_d != '0) begin
      dg_cur    = dg_left_d;
      dg_left_d = dg_cur - CW'(1);
      avail     = SZW'(dg_cur) + SZW'(HdrBytes - 1);

      if (cfg_i.whole_datagram_mode) begin
        res_o[0].out_byte     = in_data_i.in_byte;
        res_o[0].packet_start = first_d;
        res_o[0].packet_end   = (dg_cur == CW'(1)) || in_data_i.datagram_last;
        res_o[0].run_last     = 1'b1;
        push_o.count          = 3'd1;
        first_d               = 1'b0;
      end else if (pkt_left_d != '0) begin
        res_o[0].out_byte     = in_data_i.in_byte;
        res_o[0].packet_start = 1'b0;
        res_o[0].packet_end   = (pkt_left_d == CW'(1)) || in_data_i.datagram_last;
        res_o[0].run_last     = 1'b1;
        push_o.count          = 3'd1;
        pkt_left_d            = pkt_left_d - CW'(1);
      end else if (hcnt_d == 2'd0 && dg_cur < CW'(HdrBytes)) begin
        disc_d = 1'b1;
      end else if (hcnt_d != 2'd3) begin
        hold_d[hcnt_d] = in_data_i.in_byte;
        hcnt_d         = hcnt_d + 2'd1;
      end else begin
        hdr_ok = (hold_q[1] >= cfg_i.type_min) && (hold_q[1] <= cfg_i.type_max)
                 && !(first_d && hold_q[0][PadBit])
                 && !(pkt_size > avail);
        hcnt_d  = '0;
        first_d = 1'b0;
        if (hdr_ok) begin
          res_o[0] = '{out_byte: hold_q[0], packet_start: 1'b1,
                       packet_end: 1'b0, run_last: 1'b0};
          res_o[1] = '{out_byte: hold_q[1], packet_start: 1'b0,
                       packet_end: 1'b0, run_last: 1'b0};
          res_o[2] = '{out_byte: hold_q[2], packet_start: 1'b0,
                       packet_end: 1'b0, run_last: 1'b0};
          res_o[3] = '{out_byte: in_data_i.in_byte, packet_start: 1'b0,
                       packet_end: (len_word == 16'd0), run_last: 1'b1};
          push_o.count = 3'(MaxResults);
          pkt_left_d   = CW'(SZW'(len_word) << 2);
        end else begin
          disc_d = 1'b1;
        end
      end
    end

    if (in_data_i.datagram_last) begin
      dg_left_d  = '0;
      pkt_left_d = '0;
      hcnt_d     = '0;
      disc_d     = 1'b0;
    end

    if (!in_fire_i) begin
      push_o = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q     <= '0;
      dg_left_q  <= '0;
      pkt_left_q <= '0;
      first_q    <= 1'b1;
      disc_q     <= 1'b0;
    end else if (in_fire_i) begin
      hcnt_q     <= hcnt_d;
      dg_left_q  <= dg_left_d;
      pkt_left_q <= pkt_left_d;
      first_q    <= first_d;
      disc_q     <= disc_d;
    end
  end

endmodule

// ===== src/rcs_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_out_fifo
// Result queue: takes a burst of up to four results per cycle, drains one when the output is ready.
// ----------------------------------------------------------------------------
module rcs_out_fifo (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  rcs_pkg::push_t                               push_i,
  input  rcs_pkg::out_item_t [rcs_pkg::MaxResults-1:0] res_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output rcs_pkg::out_item_t                           out_data_o,
  output logic [$clog2(rcs_pkg::ResDepth+1)-1:0]       count_o
);
  import rcs_pkg::*;

  localparam int unsigned PW = $clog2(ResDepth);
  localparam int unsigned NW = $clog2(ResDepth + 1);

  out_item_t   mem_q [ResDepth];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign count_o     = cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(push_i.count);
    rd_ptr_d = rd_ptr_q + PW'(pop);
    cnt_d    = cnt_q + NW'(push_i.count) - NW'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxResults; k++) begin
      if (3'(k) < push_i.count) begin
        mem_q[wr_ptr_q + PW'(k)] <= res_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== src/rtcp_compound_splitter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcp_compound_splitter_top
// Splits byte-serial UDP datagrams into RTCP packets.
// ----------------------------------------------------------------------------
// Takes one datagram byte per cycle. Each byte is processed in the cycle it
// is accepted and its results (none, one, or a four-byte header burst) are
// written into an eight-entry result queue that drains one result per
// cycle while the output is ready. Input ready is high while the queue has
// room for a full burst, so with the output ready the sustained rate is one
// byte per clock; the extra output work of each header burst is covered by
// the three silent header bytes before it. Configuration is taken at any
// time with no wait state and should be written only between datagrams.
module rtcp_compound_splitter_top #(
  parameter int unsigned MAX_DATAGRAM = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rcs_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rcs_pkg::out_item_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rcs_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [7:0]                      cfg_data_i
);
  import rcs_pkg::*;

  localparam int unsigned NW = $clog2(ResDepth + 1);

  cfg_t                       cfg_q;
  logic                       in_fire;
  push_t                      push;
  out_item_t [MaxResults-1:0] res;
  logic [NW-1:0]              fifo_cnt;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (fifo_cnt <= NW'(ResDepth - MaxResults));
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.type_min            <= TypeMinReset;
      cfg_q.type_max            <= TypeMaxReset;
      cfg_q.whole_datagram_mode <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TYPE_MIN:   cfg_q.type_min            <= cfg_data_i;
        CFG_TYPE_MAX:   cfg_q.type_max            <= cfg_data_i;
        CFG_WHOLE_MODE: cfg_q.whole_datagram_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  rcs_core #(
    .MAX_DATAGRAM(MAX_DATAGRAM)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_fire_i (in_fire),
    .in_data_i (in_data_i),
    .push_o    (push),
    .res_o     (res)
  );

  rcs_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .count_o     (fifo_cnt)
  );

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt <= NW'(ResDepth))
    else $error("result queue overflow");

  a_push_sizes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count == 3'd0 || push.count == 3'd1 || push.count == 3'(MaxResults))
    else $error("bad result count");

  a_burst_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count == 3'(MaxResults) |-> res[0].packet_start && res[3].run_last
                                     && !res[0].run_last)
    else $error("header burst marks wrong");

  a_push_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count != 3'd0 |-> in_fire)
    else $error("results without an accepted byte");

  a_valid_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result withdrawn without a transaction");

endmodule
